// ===== hw/rtl/tmr_pkg.sv =====
// tone mapper package: commands, fixed widths and the srgb threshold table
// no dependencies; the table is built at elaboration by constant functions
package tmr_pkg;

    localparam int CMD_W   = 2;
    localparam int ALPHA_W = 17;
    localparam int BYTE_W  = 8;
    localparam int QW      = 32;
    localparam int LIN_W   = 25;
    localparam int LEVELS  = 255;

    localparam logic [CMD_W-1:0] CMD_NEW_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCAN      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MAP       = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESERVED  = 2'd3;

    localparam logic [LIN_W-1:0] LIN_ONE = 25'h100_0000;

    typedef logic [LIN_W-1:0] t_thr_arr [LEVELS];

    // log2 with 30 fraction bits by repeated squaring of the normalized mantissa
    function automatic longint lg_fx(input longint unsigned v);
        longint unsigned m;
        longint          frac;
        int              n;
        frac = 0;
        n    = 63;
        if (v == 0) begin
            return 0;
        end
        while (n > 0 && v[n] == 1'b0) begin
            n--;
        end
        if (n >= 31) begin
            m = v >> (n - 31);
        end else begin
            m = v << (31 - n);
        end
        for (int i = 1; i <= 30; i++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m    = m >> 1;
                frac = frac | (longint'(1) << (30 - i));
            end
        end
        return longint'(n) * (longint'(1) << 30) + frac;
    endfunction

    function automatic bit level_ok(input longint unsigned x, input longint unsigned k);
        longint lhs;
        longint rhs;
        if (x * 64'd10000000 < 64'd31308 * 64'd16777216) begin
            return (64'd1292 * 64'd255 * x) >= (64'd100 * k * 64'd16777216);
        end
        lhs = 5 * (lg_fx(x) - longint'(24) * (longint'(1) << 30));
        rhs = 12 * (lg_fx(64'd1000 * k + 64'd14025) - lg_fx(64'd269025));
        return lhs >= rhs;
    endfunction

    function automatic t_thr_arr build_thr();
        t_thr_arr        t;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        for (int k = 1; k <= LEVELS; k++) begin
            lo = 0;
            hi = 64'd16777216;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (level_ok(mid, longint'(k))) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            t[k-1] = lo[LIN_W-1:0];
        end
        return t;
    endfunction

    localparam t_thr_arr THR = build_thr();

endpackage

// ===== hw/rtl/tmr_if.sv =====
// pixel and byte channel interfaces for the tone mapper
// depends on tmr_pkg for fixed field widths
interface tmr_pix_if #(parameter int CW = 24);
    logic                        valid;
    logic                        ready;
    logic [tmr_pkg::CMD_W-1:0]   cmd;
    logic [CW-1:0]               red_in;
    logic [CW-1:0]               green_in;
    logic [CW-1:0]               blue_in;
    logic [tmr_pkg::ALPHA_W-1:0] alpha_in;
    modport source(output valid, cmd, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink(input valid, cmd, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface tmr_byte_if;
    logic                       valid;
    logic                       ready;
    logic [tmr_pkg::BYTE_W-1:0] red_out;
    logic [tmr_pkg::BYTE_W-1:0] green_out;
    logic [tmr_pkg::BYTE_W-1:0] blue_out;
    logic [tmr_pkg::BYTE_W-1:0] alpha_out;
    modport source(output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink(input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// ===== hw/rtl/tmr_div.sv =====
// shared restoring divider, one quotient bit per cycle, 32-bit quotient
// depends on tmr_pkg for the quotient width
module tmr_div #(
    parameter int NW = 56,
    parameter int DW = 25
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [NW-1:0]          i_num,
    input  logic [DW-1:0]          i_den,
    output logic                   o_done,
    output logic [tmr_pkg::QW-1:0] o_quo
);
    localparam int QW = tmr_pkg::QW;
    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [QW-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW:0]      w_trial;

    // trial remainder with the next numerator bit shifted in
    assign w_trial = {r_rem, r_q[QW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(i_num[NW-1:QW]);
            r_q   <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= DW'(w_trial - {1'b0, r_den});
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DW-1:0];
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== hw/rtl/hdr_tone_map_reinhard_srgb.sv =====
// top level of the extended reinhard tone mapper with srgb byte encoding
// depends on tmr_pkg, tmr_if (tmr_pix_if, tmr_byte_if) and tmr_div
//
//   channel   dir  beat content                               per beat
//   i_pix     in   cmd, red/green/blue Q8.16, alpha Q1.16     new frame, scan or map
//   o_pix     out  red/green/blue/alpha bytes                 one per map beat
//
// new frame and scan beats complete in the accept cycle and i_pix stays ready
// a map beat runs each channel in turn through the shared divider: three divisions,
// a multiply, an lq step and a binary threshold search, and a channel at or above
// its peak skips to the search; i_pix is not ready again until the output register is loaded
// synchronous active-low reset puts the peaks back to 1.0 and clears all control
// a finished result waits in the output register; the block only stalls when a second
// result is ready before the first has been taken
module hdr_tone_map_reinhard_srgb #(
    parameter int INT_BITS  = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tmr_pix_if.sink i_pix,
    tmr_byte_if.source o_pix
);
    localparam int CW = INT_BITS + FRAC_BITS;
    localparam int QW = tmr_pkg::QW;
    localparam int NW = CW + QW;
    localparam int DW = CW + 1;
    localparam int LW = tmr_pkg::LIN_W;
    localparam int BW = tmr_pkg::BYTE_W;
    localparam logic [CW-1:0] UNITY = CW'(1) << FRAC_BITS;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_PREP = 9'b0_0000_0010,
        S_DIVA = 9'b0_0000_0100,
        S_DIVE = 9'b0_0000_1000,
        S_DIVB = 9'b0_0001_0000,
        S_MUL  = 9'b0_0010_0000,
        S_LQ   = 9'b0_0100_0000,
        S_SRCH = 9'b0_1000_0000,
        S_DONE = 9'b1_0000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_pix  [3];
    logic [CW-1:0] r_peak [3];
    logic [1:0]    r_chan;
    logic [QW-1:0] r_a;
    logic [QW-1:0] r_b;
    logic [2*QW-1:0] r_prod;
    logic [LW-1:0] r_lq;
    logic [BW-1:0] r_lo;
    logic [BW-1:0] r_hi;
    logic [BW-1:0] r_byte [3];
    logic [BW-1:0] r_alpha;
    logic          r_out_valid;
    logic [BW-1:0] r_o_red, r_o_green, r_o_blue, r_o_alpha;

    logic          w_acc;
    logic          w_out_free;
    logic [CW-1:0] w_c;
    logic [CW-1:0] w_m;
    logic          w_div_go;
    logic [NW-1:0] w_div_num;
    logic [DW-1:0] w_div_den;
    logic          w_div_done;
    logic [QW-1:0] w_div_quo;
    logic [BW:0]   w_sum;
    logic [BW-1:0] w_mid;
    logic [LW-1:0] w_thr;
    logic [2*QW:0] w_lsum;
    logic [LW:0]   w_lq_raw;
    logic [tmr_pkg::ALPHA_W+BW-1:0] w_aprod;
    logic [tmr_pkg::ALPHA_W+BW-17:0] w_av;

    assign i_pix.ready = (r_state == S_IDLE);
    assign w_acc       = i_pix.valid && i_pix.ready;
    assign w_out_free  = !r_out_valid || o_pix.ready;

    // channel under work and its peak
    assign w_c = r_pix[r_chan];
    assign w_m = r_peak[r_chan];

    // alpha: floor(255 * a / 2^16), saturated
    assign w_aprod = {i_pix.alpha_in, 8'd0} - {8'd0, i_pix.alpha_in};
    assign w_av    = w_aprod[tmr_pkg::ALPHA_W+BW-1:16];

    // binary search step over the threshold table
    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi} + (BW+1)'(1);
    assign w_mid = w_sum[BW:1];
    assign w_thr = tmr_pkg::THR[w_mid - BW'(1)];

    // lq = floor(a * (2^32 + b) / 2^40), clamped to one
    assign w_lsum   = {1'b0, r_a, {QW{1'b0}}} + {1'b0, r_prod};
    assign w_lq_raw = {1'b0, w_lsum[2*QW:40]};

    tmr_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // divider launches: a = c/(1+c), e = c/m, b = e/m
    always_comb begin
        w_div_go  = 1'b0;
        w_div_num = {w_c, {QW{1'b0}}};
        w_div_den = {1'b0, w_m};
        case (r_state)
            S_PREP: begin
                w_div_go  = (w_c < w_m);
                w_div_den = DW'({1'b0, UNITY}) + DW'({1'b0, w_c});
            end
            S_DIVA: begin
                w_div_go = w_div_done;
            end
            S_DIVE: begin
                w_div_go  = w_div_done;
                w_div_num = NW'({w_div_quo, {FRAC_BITS{1'b0}}});
            end
            default: begin
                w_div_go = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_acc && i_pix.cmd == tmr_pkg::CMD_MAP) n_state = S_PREP;
            S_PREP: n_state = (w_c < w_m) ? S_DIVA : S_SRCH;
            S_DIVA: if (w_div_done) n_state = S_DIVE;
            S_DIVE: if (w_div_done) n_state = S_DIVB;
            S_DIVB: if (w_div_done) n_state = S_MUL;
            S_MUL:  n_state = S_LQ;
            S_LQ:   n_state = S_SRCH;
            S_SRCH: begin
                if (r_lo == r_hi) begin
                    n_state = (r_chan == 2'd2) ? S_DONE : S_PREP;
                end
            end
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control: state, peaks, channel index, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_chan      <= 2'd0;
            for (int i = 0; i < 3; i++) begin
                r_peak[i] <= UNITY;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_acc) begin
                r_chan <= 2'd0;
                if (i_pix.cmd == tmr_pkg::CMD_NEW_FRAME) begin
                    for (int i = 0; i < 3; i++) begin
                        r_peak[i] <= UNITY;
                    end
                end else if (i_pix.cmd == tmr_pkg::CMD_SCAN) begin
                    if (i_pix.red_in > r_peak[0])   r_peak[0] <= i_pix.red_in;
                    if (i_pix.green_in > r_peak[1]) r_peak[1] <= i_pix.green_in;
                    if (i_pix.blue_in > r_peak[2])  r_peak[2] <= i_pix.blue_in;
                end
            end
            if (r_state == S_SRCH && r_lo == r_hi && r_chan != 2'd2) begin
                r_chan <= r_chan + 2'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pix[0] <= i_pix.red_in;
            r_pix[1] <= i_pix.green_in;
            r_pix[2] <= i_pix.blue_in;
            r_alpha  <= (w_av > (tmr_pkg::ALPHA_W-8)'(255)) ? 8'hff : w_av[BW-1:0];
        end
        case (r_state)
            S_PREP: begin
                r_lq <= tmr_pkg::LIN_ONE;
                r_lo <= '0;
                r_hi <= BW'(tmr_pkg::LEVELS);
            end
            S_DIVA: if (w_div_done) r_a <= w_div_quo;
            S_DIVB: if (w_div_done) r_b <= w_div_quo;
            S_MUL:  r_prod <= r_a * r_b;
            S_LQ: begin
                r_lq <= (w_lq_raw > {1'b0, tmr_pkg::LIN_ONE}) ? tmr_pkg::LIN_ONE
                                                              : w_lq_raw[LW-1:0];
            end
            S_SRCH: begin
                if (r_lo == r_hi) begin
                    r_byte[r_chan] <= r_lo;
                end else if (w_thr <= r_lq) begin
                    r_lo <= w_mid;
                end else begin
                    r_hi <= w_mid - BW'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_o_red   <= r_byte[0];
                    r_o_green <= r_byte[1];
                    r_o_blue  <= r_byte[2];
                    r_o_alpha <= r_alpha;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.red_out   = r_o_red;
    assign o_pix.green_out = r_o_green;
    assign o_pix.blue_out  = r_o_blue;
    assign o_pix.alpha_out = r_o_alpha;

`ifndef SYNTHESIS
    a_peak_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak[0] >= UNITY && r_peak[1] >= UNITY && r_peak[2] >= UNITY)
        else $error("peak below one");
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SRCH |-> r_lo <= r_hi)
        else $error("search bounds crossed");
    a_lq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SRCH |-> r_lq <= tmr_pkg::LIN_ONE)
        else $error("lq above one");
    a_map_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_pix.cmd == tmr_pkg::CMD_MAP |=> !i_pix.ready && r_chan == 2'd0)
        else $error("map beat did not start the sequencer");
`endif

endmodule
